### design/cscls_pkg.sv
package cscls_pkg;

   localparam int PERIOD_BITS_DEF = 17;
   localparam int FREQ_BITS_DEF = 19;
   localparam int REG_BITS = 19;
   localparam int CSR_ADDR_BITS = 3;
   localparam int LEVEL_BITS = 8;
   localparam int CLASS_BITS = 3;
   localparam int HALF_SCALE = 500000;
   localparam int BYTE_SPAN = 255;
   localparam int QUOT_BITS = 19;
   localparam int NUM_BITS = 27;

   localparam logic [CSR_ADDR_BITS-1:0] REG_WHITE = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_BALANCE = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] REG_RED_LOW = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] REG_RED_HIGH = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] REG_GREEN_LOW = 3'd4;
   localparam logic [CSR_ADDR_BITS-1:0] REG_GREEN_HIGH = 3'd5;
   localparam logic [CSR_ADDR_BITS-1:0] REG_BLUE_LOW = 3'd6;
   localparam logic [CSR_ADDR_BITS-1:0] REG_BLUE_HIGH = 3'd7;

   localparam logic [CLASS_BITS-1:0] CLASS_WHITE = 3'd0;
   localparam logic [CLASS_BITS-1:0] CLASS_RED = 3'd1;
   localparam logic [CLASS_BITS-1:0] CLASS_BLUE = 3'd2;
   localparam logic [CLASS_BITS-1:0] CLASS_GREEN = 3'd3;
   localparam logic [CLASS_BITS-1:0] CLASS_UNKNOWN = 3'd4;

   // calibration window of one lane
   typedef struct packed {
      logic [REG_BITS-1:0] low;
      logic [REG_BITS-1:0] high;
   } window_type;

endpackage

### design/color_sensor_rgb_classifier.sv
// Color sensor classifier. Takes one item per cycle (busy is always low) and
// passes each through two bit-per-stage divider pipelines in each lane
// (19 stages for the frequency, then 27 for byte scaling) plus the clamp and
// merge registers. The receiver cannot stall; rsp_valid pulses for one cycle
// per item.
// Configuration writes are always accepted and take effect at once, so they
// should only be made with no item in flight.
module color_sensor_rgb_classifier #(
   parameter int PERIOD_BITS = cscls_pkg::PERIOD_BITS_DEF,
   parameter int FREQ_BITS = cscls_pkg::FREQ_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [PERIOD_BITS-1:0] req_red_half_period,
   input  logic [PERIOD_BITS-1:0] req_blue_half_period,
   input  logic [PERIOD_BITS-1:0] req_green_half_period,
   output logic                   rsp_valid,
   output logic [cscls_pkg::LEVEL_BITS-1:0] rsp_red_level,
   output logic [cscls_pkg::LEVEL_BITS-1:0] rsp_green_level,
   output logic [cscls_pkg::LEVEL_BITS-1:0] rsp_blue_level,
   output logic [cscls_pkg::CLASS_BITS-1:0] rsp_color_class,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [cscls_pkg::CSR_ADDR_BITS-1:0] csr_index,
   input  logic [cscls_pkg::REG_BITS-1:0]      csr_data
);
   import cscls_pkg::*;

   assign busy = 1'b0;
   assign csr_ready = 1'b1;

   // configuration registers
   logic [REG_BITS-1:0] white_ff, balance_ff;
   window_type red_ff, green_ff, blue_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         white_ff <= REG_BITS'(40000);
         balance_ff <= REG_BITS'(5000);
         red_ff <= '{low: REG_BITS'(2500), high: REG_BITS'(20000)};
         green_ff <= '{low: REG_BITS'(2000), high: REG_BITS'(15000)};
         blue_ff <= '{low: REG_BITS'(2500), high: REG_BITS'(12000)};
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_WHITE:      white_ff <= csr_data;
            REG_BALANCE:    balance_ff <= csr_data;
            REG_RED_LOW:    red_ff.low <= csr_data;
            REG_RED_HIGH:   red_ff.high <= csr_data;
            REG_GREEN_LOW:  green_ff.low <= csr_data;
            REG_GREEN_HIGH: green_ff.high <= csr_data;
            REG_BLUE_LOW:   blue_ff.low <= csr_data;
            REG_BLUE_HIGH:  blue_ff.high <= csr_data;
            default: ;
         endcase
      end
   end

   // three lanes
   logic vr, vg, vb;
   logic [FREQ_BITS-1:0] fr, fg, fb;
   logic [LEVEL_BITS-1:0] lr, lg, lb;

   cscls_lane #(.PERIOD_BITS(PERIOD_BITS), .FREQ_BITS(FREQ_BITS)) u_red (
      .clock(clock), .reset(reset), .in_valid(start), .in_width(req_red_half_period),
      .window(red_ff), .out_valid(vr), .out_freq(fr), .out_level(lr));
   cscls_lane #(.PERIOD_BITS(PERIOD_BITS), .FREQ_BITS(FREQ_BITS)) u_green (
      .clock(clock), .reset(reset), .in_valid(start), .in_width(req_green_half_period),
      .window(green_ff), .out_valid(vg), .out_freq(fg), .out_level(lg));
   cscls_lane #(.PERIOD_BITS(PERIOD_BITS), .FREQ_BITS(FREQ_BITS)) u_blue (
      .clock(clock), .reset(reset), .in_valid(start), .in_width(req_blue_half_period),
      .window(blue_ff), .out_valid(vb), .out_freq(fb), .out_level(lb));

   // merge stage
   cscls_merge #(.FREQ_BITS(FREQ_BITS)) u_merge (
      .clock(clock), .reset(reset), .in_valid(vr & vg & vb),
      .fr(fr), .fg(fg), .fb(fb), .lr(lr), .lg(lg), .lb(lb),
      .white_level(white_ff), .balance_limit(balance_ff),
      .out_valid(rsp_valid), .out_r(rsp_red_level), .out_g(rsp_green_level),
      .out_b(rsp_blue_level), .out_class(rsp_color_class));
endmodule

### design/cscls_divider.sv
// pipelined restoring divider, one quotient bit per stage
module cscls_divider #(
   parameter int NUM_W = 27,
   parameter int DEN_W = 19,
   parameter int Q_W = 19,
   parameter int TAG_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [Q_W-1:0]   out_quot,
   output logic [TAG_W-1:0] out_tag
);
   localparam int RW = DEN_W + 1;

   logic             valid_ff [Q_W+1];
   logic [NUM_W-1:0] num_ff [Q_W+1];
   logic [DEN_W-1:0] den_ff [Q_W+1];
   logic [RW-1:0]    rem_ff [Q_W+1];
   logic [Q_W-1:0]   quot_ff [Q_W+1];
   logic [TAG_W-1:0] tag_ff [Q_W+1];

   // stage 0 takes the operands
   always_comb begin
      valid_ff[0] = in_valid;
      num_ff[0] = in_num;
      den_ff[0] = in_den;
      rem_ff[0] = '0;
      quot_ff[0] = '0;
      tag_ff[0] = in_tag;
   end

   for (genvar s = 0; s < Q_W; s++) begin : g_stage
      localparam int BIT = Q_W - 1 - s;
      logic [RW:0] trial;
      logic [RW-1:0] rem_in;
      logic [Q_W-1:0] quot_in;
      always_comb begin
         trial = {rem_ff[s], num_ff[s][BIT]};
         rem_in = trial[RW-1:0];
         quot_in = quot_ff[s];
         if (trial >= {2'b00, den_ff[s]}) begin
            rem_in = RW'(trial - {2'b00, den_ff[s]});
            quot_in[BIT] = 1'b1;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) valid_ff[s+1] <= 1'b0;
         else valid_ff[s+1] <= valid_ff[s];
         num_ff[s+1] <= num_ff[s];
         den_ff[s+1] <= den_ff[s];
         rem_ff[s+1] <= rem_in;
         quot_ff[s+1] <= quot_in;
         tag_ff[s+1] <= tag_ff[s];
      end
   end

   assign out_valid = valid_ff[Q_W];
   assign out_quot = quot_ff[Q_W];
   assign out_tag = tag_ff[Q_W];
endmodule

### design/cscls_lane.sv
// one color channel: width to frequency, clamp, scale to a byte
module cscls_lane #(
   parameter int PERIOD_BITS = 17,
   parameter int FREQ_BITS = 19
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [PERIOD_BITS-1:0]     in_width,
   input  cscls_pkg::window_type      window,
   output logic                       out_valid,
   output logic [FREQ_BITS-1:0]       out_freq,
   output logic [cscls_pkg::LEVEL_BITS-1:0] out_level
);
   import cscls_pkg::*;

   localparam int HS_BITS = 19;
   localparam int FQ_BITS = HS_BITS;
   localparam int FMAX = (1 << FREQ_BITS) - 1;
   localparam int NW = REG_BITS + LEVEL_BITS;

   // frequency divider, width 0 maps to 0 through a tag
   logic f_valid, f_zero;
   logic [FQ_BITS-1:0] f_quot;
   logic [FREQ_BITS-1:0] freq;
   logic [FQ_BITS+FREQ_BITS-1:0] f_wide;

   cscls_divider #(.NUM_W(HS_BITS), .DEN_W(PERIOD_BITS), .Q_W(FQ_BITS), .TAG_W(1)) u_fdiv (
      .clock(clock), .reset(reset), .in_valid(in_valid), .in_num(HS_BITS'(HALF_SCALE)),
      .in_den(in_width), .in_tag(in_width == '0),
      .out_valid(f_valid), .out_quot(f_quot), .out_tag(f_zero)
   );

   always_comb begin
      f_wide = (FQ_BITS+FREQ_BITS)'(f_quot);
      if (f_zero) freq = '0;
      else if (f_wide > (FQ_BITS+FREQ_BITS)'(FMAX)) freq = FREQ_BITS'(FMAX);
      else freq = FREQ_BITS'(f_quot);
   end

   // clamp and numerator stage
   localparam int CW = (FREQ_BITS > REG_BITS) ? FREQ_BITS : REG_BITS;
   logic c_valid_ff, c_empty_ff;
   logic [NW-1:0] c_num_ff;
   logic [REG_BITS-1:0] c_den_ff;
   logic [FREQ_BITS-1:0] c_freq_ff;
   logic [CW-1:0] x, lo, hi;

   always_comb begin
      lo = CW'(window.low);
      hi = CW'(window.high);
      x = CW'(freq);
      if (x < lo) x = lo;
      if (x > hi) x = hi;
   end

   always_ff @(posedge clock) begin
      if (reset) c_valid_ff <= 1'b0;
      else c_valid_ff <= f_valid;
      c_empty_ff <= window.high <= window.low;
      c_num_ff <= NW'(REG_BITS'(x - lo)) * NW'(BYTE_SPAN);
      c_den_ff <= window.high - window.low;
      c_freq_ff <= freq;
   end

   // byte divider carries frequency and empty flag along
   logic [LEVEL_BITS-1:0] s_quot;
   logic [FREQ_BITS:0] s_tag;
   logic [NW-1:0] s_q_full;

   cscls_divider #(.NUM_W(NW), .DEN_W(REG_BITS), .Q_W(NW), .TAG_W(FREQ_BITS+1)) u_sdiv (
      .clock(clock), .reset(reset), .in_valid(c_valid_ff), .in_num(c_num_ff),
      .in_den(c_den_ff), .in_tag({c_empty_ff, c_freq_ff}),
      .out_valid(out_valid), .out_quot(s_q_full), .out_tag(s_tag)
   );

   assign s_quot = s_q_full[LEVEL_BITS-1:0];
   assign out_freq = s_tag[FREQ_BITS-1:0];
   assign out_level = s_tag[FREQ_BITS] ? '0 : s_quot;
endmodule

### design/cscls_merge.sv
// merge: white test and strict maximum over the three lanes
module cscls_merge #(
   parameter int FREQ_BITS = 19
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [FREQ_BITS-1:0] fr,
   input  logic [FREQ_BITS-1:0] fg,
   input  logic [FREQ_BITS-1:0] fb,
   input  logic [cscls_pkg::LEVEL_BITS-1:0] lr,
   input  logic [cscls_pkg::LEVEL_BITS-1:0] lg,
   input  logic [cscls_pkg::LEVEL_BITS-1:0] lb,
   input  logic [cscls_pkg::REG_BITS-1:0]   white_level,
   input  logic [cscls_pkg::REG_BITS-1:0]   balance_limit,
   output logic                 out_valid,
   output logic [cscls_pkg::LEVEL_BITS-1:0] out_r,
   output logic [cscls_pkg::LEVEL_BITS-1:0] out_g,
   output logic [cscls_pkg::LEVEL_BITS-1:0] out_b,
   output logic [cscls_pkg::CLASS_BITS-1:0] out_class
);
   import cscls_pkg::*;

   localparam int W = (FREQ_BITS > REG_BITS) ? FREQ_BITS : REG_BITS;

   logic [W-1:0] r, g, b, wl, bl, drg, drb, dgb;
   logic white;
   logic [CLASS_BITS-1:0] class_in;

   always_comb begin
      r = W'(fr);
      g = W'(fg);
      b = W'(fb);
      wl = W'(white_level);
      bl = W'(balance_limit);
      drg = (r > g) ? r - g : g - r;
      drb = (r > b) ? r - b : b - r;
      dgb = (g > b) ? g - b : b - g;
      white = r > wl && g > wl && b > wl && drg < bl && drb < bl && dgb < bl;
      if (white) class_in = CLASS_WHITE;
      else if (r > b && r > g) class_in = CLASS_RED;
      else if (b > r && b > g) class_in = CLASS_BLUE;
      else if (g > r && g > b) class_in = CLASS_GREEN;
      else class_in = CLASS_UNKNOWN;
   end

   logic valid_ff;
   logic [LEVEL_BITS-1:0] r_ff, g_ff, b_ff;
   logic [CLASS_BITS-1:0] class_ff;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= in_valid;
      r_ff <= lr;
      g_ff <= lg;
      b_ff <= lb;
      class_ff <= class_in;
   end

   assign out_valid = valid_ff;
   assign out_r = r_ff;
   assign out_g = g_ff;
   assign out_b = b_ff;
   assign out_class = class_ff;
endmodule
